// File: rtl/tes_pkg.sv
package tes_pkg;

    // Event queue sizing and time width.
    localparam int FIFO_DEPTH  = 16;
    localparam int TIME_BITS   = 32;

    // The pending slot lives at the head of the queue, so the queue holds one extra entry.
    localparam int QUEUE_DEPTH = FIFO_DEPTH + 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [SUM_W-1:0]     t_sum;

    // Request type codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START_TIME = 2'd0;
    localparam t_cfg_idx CFG_RUN_ENABLE = 2'd1;
    localparam t_cfg_idx CFG_OUTPUT_PIN = 2'd2;

    // One stored event.
    typedef struct packed {
        logic  level;
        t_time offset;
    } t_event;

    // Queue controls from the sequencer.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_event wdata;
    } t_q_ctrl;

    // Queue status back to the sequencer.
    typedef struct packed {
        t_event front;
        t_cnt   count;
    } t_q_stat;

endpackage

// File: rtl/timed_output_event_sequencer.sv
// Channel   Direction  Handshake                 Word
// request   in         i_valid / o_ready         i_req_type, i_event_level, i_event_offset,
//                                                i_now_ms
// result    out        o_valid / i_ready         o_switched, o_pin_index, o_drive_level,
//                                                o_fired_offset, o_current_level, o_active,
//                                                o_dropped
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word per cycle sustained while results are taken; each word is registered in the
// input register and then in the result register, handled in one pass between them; the
// pending event sits at the head of the register queue, so one front read serves a tick.
// Reset clears the queue pointers, flags, config and valid bits at once; no clearing pass.
// A stalled result holds in the result register while the next word waits in the input
// register; ready drops only when both are full. Config writes are always ready.
module timed_output_event_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic        i_event_level,
    input  logic [31:0] i_event_offset,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_switched,
    output logic [3:0]  o_pin_index,
    output logic        o_drive_level,
    output logic [31:0] o_fired_offset,
    output logic        o_current_level,
    output logic        o_active,
    output logic        o_dropped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers.
    tes_pkg::t_time r_start_time;
    logic           r_run_enable;
    logic [3:0]     r_output_pin;

    // Input register.
    logic           r_in_valid;
    logic           r_in_req_type;
    logic           r_in_level;
    logic [31:0]    r_in_offset;
    logic [31:0]    r_in_now;

    // Sequencer state.
    logic           r_pend;
    logic           r_finished;
    logic           r_last_level;
    logic           n_pend;
    logic           n_finished;
    logic           n_last_level;

    // Result register.
    logic           r_out_valid;
    logic           r_out_switched;
    logic [3:0]     r_out_pin;
    logic           r_out_drive;
    logic [31:0]    r_out_offset;
    logic           r_out_cur_level;
    logic           r_out_active;
    logic           r_out_dropped;
    logic           n_switched;
    logic [3:0]     n_pin;
    logic           n_drive;
    logic [31:0]    n_offset;
    logic           n_cur_level;
    logic           n_dropped;

    logic             advance;
    logic             fire;
    tes_pkg::t_time   due;
    tes_pkg::t_cnt    fifo_cnt;
    tes_pkg::t_cnt    n_q_count;
    tes_pkg::t_cnt    n_fifo_cnt;
    tes_pkg::t_q_ctrl q_ctrl;
    tes_pkg::t_q_stat q_stat;

    tes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .o_stat  (q_stat)
    );

    // The input word moves on when the result register is free or being emptied.
    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_run_enable <= 1'b0;
            r_output_pin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tes_pkg::CFG_START_TIME: r_start_time <= tes_pkg::t_time'(i_cfg_data);
                tes_pkg::CFG_RUN_ENABLE: r_run_enable <= i_cfg_data[0];
                tes_pkg::CFG_OUTPUT_PIN: r_output_pin <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_req_type <= i_req_type;
            r_in_level    <= i_event_level;
            r_in_offset   <= i_event_offset;
            r_in_now      <= i_now_ms;
        end
    end

    // Events waiting behind the pending slot.
    assign fifo_cnt = q_stat.count - tes_pkg::t_cnt'(r_pend);
    assign due      = r_start_time + q_stat.front.offset;
    assign fire     = tes_pkg::t_time'(r_in_now) >= due;

    // One pass over the word: push, or tick against the head event.
    always_comb begin
        q_ctrl.push         = 1'b0;
        q_ctrl.pop          = 1'b0;
        q_ctrl.wdata.level  = r_in_level;
        q_ctrl.wdata.offset = tes_pkg::t_time'(r_in_offset);
        n_pend       = r_pend;
        n_finished   = r_finished;
        n_last_level = r_last_level;
        n_switched   = 1'b0;
        n_pin        = '0;
        n_drive      = 1'b0;
        n_offset     = '0;
        n_dropped    = 1'b0;
        if (advance) begin
            if (r_in_req_type == tes_pkg::REQ_PUSH) begin
                if (fifo_cnt >= tes_pkg::t_cnt'(tes_pkg::FIFO_DEPTH)) begin
                    n_dropped = 1'b1;
                end else begin
                    q_ctrl.push = 1'b1;
                end
            end else if (r_run_enable && !r_finished) begin
                if (q_stat.count == '0) begin
                    n_finished = 1'b1;
                end else if (fire) begin
                    n_switched   = 1'b1;
                    n_pin        = r_output_pin;
                    n_drive      = q_stat.front.level;
                    n_offset     = 32'(q_stat.front.offset);
                    n_last_level = q_stat.front.level;
                    q_ctrl.pop   = 1'b1;
                    // The last event fired: sequencing is over.
                    if (q_stat.count == tes_pkg::t_cnt'(1)) begin
                        n_finished = 1'b1;
                        n_pend     = 1'b0;
                    end else begin
                        n_pend = 1'b1;
                    end
                end else begin
                    n_pend = 1'b1;
                end
            end
        end
        n_q_count   = q_stat.count + tes_pkg::t_cnt'(q_ctrl.push)
                      - tes_pkg::t_cnt'(q_ctrl.pop);
        n_fifo_cnt  = n_q_count - tes_pkg::t_cnt'(n_pend);
        n_cur_level = (n_fifo_cnt == '0) ? 1'b0 : n_last_level;
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend       <= 1'b0;
            r_finished   <= 1'b0;
            r_last_level <= 1'b0;
        end else begin
            r_pend       <= n_pend;
            r_finished   <= n_finished;
            r_last_level <= n_last_level;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_switched  <= n_switched;
            r_out_pin       <= n_pin;
            r_out_drive     <= n_drive;
            r_out_offset    <= n_offset;
            r_out_cur_level <= n_cur_level;
            r_out_active    <= !n_finished;
            r_out_dropped   <= n_dropped;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_switched      = r_out_switched;
    assign o_pin_index     = r_out_pin;
    assign o_drive_level   = r_out_drive;
    assign o_fired_offset  = r_out_offset;
    assign o_current_level = r_out_cur_level;
    assign o_active        = r_out_active;
    assign o_dropped       = r_out_dropped;

`ifndef SYNTHESIS
    // A pending event always occupies the head of the queue.
    a_pend_in_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (q_stat.count != '0))
        else $error("pending event without a queue entry");

    // The queue never holds more than the FIFO plus the pending slot.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= tes_pkg::t_cnt'(tes_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    // Finishing is permanent until reset.
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag cleared");

    // Once finished, nothing is left pending.
    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !r_pend)
        else $error("pending event after finish");

    // A stalled result is not overwritten.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

// File: rtl/tes_queue.sv
module tes_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tes_pkg::t_q_ctrl i_ctrl,
    output tes_pkg::t_q_stat o_stat
);

    tes_pkg::t_event r_mem [tes_pkg::QUEUE_DEPTH];
    tes_pkg::t_ptr   r_head;
    tes_pkg::t_cnt   r_count;
    tes_pkg::t_ptr   n_head;
    tes_pkg::t_cnt   n_count;
    tes_pkg::t_sum   tail_sum;
    tes_pkg::t_ptr   tail;

    // Tail slot is head plus count, wrapped once around the queue.
    always_comb begin
        tail_sum = tes_pkg::t_sum'(r_head) + tes_pkg::t_sum'(r_count);
        if (tail_sum >= tes_pkg::t_sum'(tes_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - tes_pkg::t_sum'(tes_pkg::QUEUE_DEPTH);
        end
        tail = tes_pkg::t_ptr'(tail_sum);
    end

    // Pointer and count updates.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head  = (r_head == tes_pkg::t_ptr'(tes_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : r_head + tes_pkg::t_ptr'(1);
            n_count = n_count - tes_pkg::t_cnt'(1);
        end
        if (i_ctrl.push) begin
            n_count = n_count + tes_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset: only pushed entries are ever read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[tail] <= i_ctrl.wdata;
        end
    end

    assign o_stat.front = r_mem[r_head];
    assign o_stat.count = r_count;

endmodule
